// File: rtl/mexp_pkg.sv
// mexp_pkg: shared widths, register indexes and unit interface types
// for the modular exponentiation block
// no dependencies
package mexp_pkg;

  // operand width of base, exponent, modulus and result
  localparam int OPERAND_BITS = 16;

  // iteration counter of the multiplier, holds 0..OPERAND_BITS
  localparam int CNT_W = $clog2(OPERAND_BITS + 1);

  // index of one exponent bit
  localparam int BIT_IDX_W = $clog2(OPERAND_BITS);

  // configuration register indexes
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  // reset values of the configuration registers
  localparam logic [OPERAND_BITS-1:0] EXPONENT_RESET = OPERAND_BITS'(9341);
  localparam logic [OPERAND_BITS-1:0] MODULUS_RESET  = OPERAND_BITS'(10579);

  // request to the shared modular multiplier
  typedef struct packed {
    logic                    start;
    logic [OPERAND_BITS-1:0] multiplicand;
    logic [OPERAND_BITS-1:0] multiplier;
  } mm_req_t;

  // response from the shared modular multiplier
  typedef struct packed {
    logic                    done;
    logic [OPERAND_BITS-1:0] product;
  } mm_rsp_t;

endpackage

// File: rtl/mexp_mulmod.sv
// mexp_mulmod: shift-add modular multiplier, one multiplier bit per cycle
// computes multiplicand * multiplier mod modulus, multiplicand below modulus
// depends on mexp_pkg
module mexp_mulmod (
  input  logic                             clk,
  input  logic                             rst,
  input  mexp_pkg::mm_req_t                req,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] modulus,
  output mexp_pkg::mm_rsp_t                rsp
);

  logic [mexp_pkg::OPERAND_BITS-1:0] acc;
  logic [mexp_pkg::OPERAND_BITS-1:0] acc_next;
  logic [mexp_pkg::OPERAND_BITS-1:0] mcand;
  logic [mexp_pkg::OPERAND_BITS-1:0] mplier;
  logic [mexp_pkg::OPERAND_BITS-1:0] mod_r;
  logic [mexp_pkg::CNT_W-1:0]        cnt;
  logic                              busy;
  logic                              done;
  logic [mexp_pkg::OPERAND_BITS+1:0] sum;
  logic [mexp_pkg::OPERAND_BITS+1:0] mod_x1;
  logic [mexp_pkg::OPERAND_BITS+1:0] mod_x2;
  logic [mexp_pkg::OPERAND_BITS+1:0] sum_red;

  // double the partial product, add the multiplicand when the top bit is set,
  // then bring it back below the modulus (sum stays below three moduli)
  always_comb begin
    mod_x1 = {2'b00, mod_r};
    mod_x2 = {1'b0, mod_r, 1'b0};
    sum    = {1'b0, acc, 1'b0}
           + (mplier[mexp_pkg::OPERAND_BITS-1] ? {2'b00, mcand} : '0);
    if (sum >= mod_x2) begin
      sum_red = sum - mod_x2;
    end else if (sum >= mod_x1) begin
      sum_red = sum - mod_x1;
    end else begin
      sum_red = sum;
    end
    acc_next = sum_red[mexp_pkg::OPERAND_BITS-1:0];
  end

  // operand capture and one iteration per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mcand  <= req.multiplicand;
      mplier <= req.multiplier;
      mod_r  <= modulus;
    end else if (busy) begin
      acc    <= acc_next;
      mplier <= {mplier[mexp_pkg::OPERAND_BITS-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= mexp_pkg::CNT_W'(mexp_pkg::OPERAND_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mexp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// File: rtl/modular_exponentiation.sv
// modular_exponentiation: top level, base ** exponent mod modulus
// left-to-right square-and-multiply sequencer around one shared modular multiplier
// depends on mexp_pkg and mexp_mulmod
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid, in_ready, base             | in
//   result   | out_valid, out_ready, power_mod      | out
//   config   | cfg_valid, cfg_ready, cfg_index,     | in
//            | cfg_data (0 exponent, 1 modulus)     |
//
// each product comes from the multiplier, which handles one multiplier bit per cycle
// a result word takes one reduction, 16 squarings and one multiplication per set exponent bit,
// and the next base can be taken once the sequencer is back in idle
// in_ready is high only while the sequencer is idle; a modulus below two gives 0
// without using the multiplier; the result register holds the word until it is taken
// rst is synchronous and restores exponent 9341 and modulus 10579
module modular_exponentiation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] base,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mexp_pkg::OPERAND_BITS-1:0] power_mod,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                        state;
  logic [mexp_pkg::OPERAND_BITS-1:0] exponent;
  logic [mexp_pkg::OPERAND_BITS-1:0] modulus;
  logic [mexp_pkg::OPERAND_BITS-1:0] base_r;
  logic [mexp_pkg::OPERAND_BITS-1:0] base_red;
  logic [mexp_pkg::OPERAND_BITS-1:0] acc;
  logic [mexp_pkg::BIT_IDX_W-1:0]    bit_idx;
  logic                              start;
  mexp_pkg::mm_req_t                 mm_req;
  mexp_pkg::mm_rsp_t                 mm_rsp;
  logic                              in_acc;
  logic                              out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= mexp_pkg::EXPONENT_RESET;
      modulus  <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        mexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mm_req.start = start;
    case (state)
      S_REDUCE: begin
        // base * 1 mod modulus reduces the base
        mm_req.multiplicand = mexp_pkg::OPERAND_BITS'(1);
        mm_req.multiplier   = base_r;
      end
      S_SQUARE: begin
        mm_req.multiplicand = acc;
        mm_req.multiplier   = acc;
      end
      S_MULT: begin
        mm_req.multiplicand = base_red;
        mm_req.multiplier   = acc;
      end
      default: begin
        mm_req.multiplicand = acc;
        mm_req.multiplier   = acc;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .req     (mm_req),
    .modulus (modulus),
    .rsp     (mm_rsp)
  );

  // square-and-multiply sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      start   <= 1'b0;
      bit_idx <= '0;
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (modulus < mexp_pkg::OPERAND_BITS'(2)) begin
              state <= S_DONE;
            end else begin
              state <= S_REDUCE;
              start <= 1'b1;
            end
          end
        end
        S_REDUCE: begin
          if (mm_rsp.done) begin
            bit_idx <= mexp_pkg::BIT_IDX_W'(mexp_pkg::OPERAND_BITS - 1);
            state   <= S_SQUARE;
            start   <= 1'b1;
          end
        end
        S_SQUARE: begin
          if (mm_rsp.done) begin
            if (exponent[bit_idx]) begin
              state <= S_MULT;
              start <= 1'b1;
            end else if (bit_idx == '0) begin
              state <= S_DONE;
            end else begin
              bit_idx <= bit_idx - 1'b1;
              start   <= 1'b1;
            end
          end
        end
        S_MULT: begin
          if (mm_rsp.done) begin
            if (bit_idx == '0) begin
              state <= S_DONE;
            end else begin
              bit_idx <= bit_idx - 1'b1;
              state   <= S_SQUARE;
              start   <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= base;
      acc    <= '0;
    end else if (mm_rsp.done) begin
      if (state == S_REDUCE) begin
        base_red <= mm_rsp.product;
        acc      <= mexp_pkg::OPERAND_BITS'(1);
      end else begin
        acc <= mm_rsp.product;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power_mod <= acc;
    end
  end

endmodule
